>>> rtl/tdl_pkg.sv
// Shared widths, codes and state types for the timed derivative block.
// No dependencies; used by every other file of the block.

package tdl_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int TIME_BITS   = 32;
    localparam int RATE_BITS   = 48;
    localparam int ALPHA_BITS  = 17;
    localparam int ALPHA_FRAC  = 16;
    localparam int ALPHA_ONE   = 1 << ALPHA_FRAC;
    localparam int MS_PER_S    = 1000;
    localparam int MS_BITS     = $clog2(MS_PER_S);

    // sample difference, and that difference scaled to per-second units
    localparam int DIFF_BITS  = SAMPLE_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + MS_BITS;
    localparam int DCNT_BITS  = $clog2(PROD_BITS);
    localparam int FCNT_BITS  = $clog2(ALPHA_FRAC);
    localparam int WIDE_BITS  = ((PROD_BITS > RATE_BITS) ? PROD_BITS : RATE_BITS) + 1;
    localparam int FDIFF_BITS = RATE_BITS + 1;
    localparam int ACC_BITS   = RATE_BITS + 2;
    localparam int KIND_BITS  = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_FIRST = 2'd0,
        KIND_HOLD  = 2'd1,
        KIND_NEW   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCALE,
        ST_DIVIDE,
        ST_APPLY,
        ST_FILTER,
        ST_UPDATE,
        ST_FINISH
    } tdl_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIX
    } div_state_t;

endpackage

>>> rtl/timed_derivative_with_lowpass.sv
// Timed derivative with optional first-order low-pass, top level.
// Depends on tdl_pkg and tdl_divider.
//
//   channel | direction | handshake           | carries
//   --------+-----------+---------------------+-------------------------------------
//   s_      | in        | s_valid / s_ready   | s_sample_value (Q15.16), s_time_ms
//   m_      | out       | m_valid / m_ready   | m_rate_value (Q31.16 /s), m_result_kind
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_filter_alpha (Q1.16)
//
// One request is worked at a time. First-sample and zero-interval requests go
// from ST_DECIDE straight to ST_FINISH. A new value runs through the bit-serial
// divider (one quotient bit per cycle over the 43-bit scaled difference); with
// the filter active and primed, a bit-serial multiply by the 16 fractional alpha
// bits and an add to the smoother follow it.
// The result register lets the next request in while m_ready holds a result off.
// aresetn is synchronous, active low; it clears all history and the weight.
// cfg_ready is always high.

module timed_derivative_with_lowpass (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // input requests
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic signed [tdl_pkg::SAMPLE_BITS-1:0]    s_sample_value,
    input  logic        [tdl_pkg::TIME_BITS-1:0]      s_time_ms,
    // results
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [tdl_pkg::RATE_BITS-1:0]      m_rate_value,
    output logic        [tdl_pkg::KIND_BITS-1:0]      m_result_kind,
    // weight register
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic        [tdl_pkg::ALPHA_BITS-1:0]     cfg_filter_alpha
);

    localparam int SB = tdl_pkg::SAMPLE_BITS;
    localparam int TB = tdl_pkg::TIME_BITS;
    localparam int RB = tdl_pkg::RATE_BITS;
    localparam int DB = tdl_pkg::DIFF_BITS;
    localparam int PB = tdl_pkg::PROD_BITS;
    localparam int FB = tdl_pkg::FDIFF_BITS;
    localparam int AB = tdl_pkg::ACC_BITS;
    localparam int AF = tdl_pkg::ALPHA_FRAC;
    localparam logic signed [tdl_pkg::MS_BITS:0] MS_SCALE =
        (tdl_pkg::MS_BITS + 1)'(tdl_pkg::MS_PER_S);
    localparam logic [tdl_pkg::ALPHA_BITS-1:0] ALPHA_UNITY =
        tdl_pkg::ALPHA_BITS'(tdl_pkg::ALPHA_ONE);

    tdl_pkg::tdl_state_t state_reg, state_next;

    // held request
    logic signed [SB-1:0] sample_in_reg;
    logic        [TB-1:0] time_in_reg;

    // history
    logic signed [SB-1:0] prev_sample_reg;
    logic        [TB-1:0] prev_time_reg;
    logic signed [RB-1:0] held_reg;
    logic signed [RB-1:0] smooth_reg;
    logic                 primed_reg;
    logic [tdl_pkg::ALPHA_BITS-1:0] alpha_reg;

    // working values
    logic signed [DB-1:0] diff_reg;
    logic        [TB-1:0] delta_reg;
    logic signed [RB-1:0] rate_reg;
    logic signed [FB-1:0] fdiff_reg;
    logic signed [AB-1:0] acc_reg;
    logic        [AF-1:0] alpha_sh_reg;
    logic [tdl_pkg::FCNT_BITS-1:0] fcnt_reg;
    tdl_pkg::kind_t       kind_reg;

    // result register
    logic                 m_valid_reg;
    logic signed [RB-1:0] m_rate_reg;
    tdl_pkg::kind_t       m_kind_reg;

    // divider hookup
    logic                 div_start;
    logic                 div_done;
    logic signed [PB-1:0] div_dividend;
    logic signed [RB-1:0] div_quotient;

    logic                 filter_on;
    logic                 out_free;
    logic signed [AB:0]   fsum;

    tdl_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (delta_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // per-second scaling: constant multiply, shift-and-add in synthesis
    assign div_dividend = PB'(PB'(diff_reg) * MS_SCALE);

    assign filter_on = (alpha_reg != '0) && (alpha_reg < ALPHA_UNITY);
    assign out_free  = !m_valid_reg || m_ready;

    // one alpha bit per step: acc = floor((acc + bit*d) / 2)
    assign fsum = (AB + 1)'(acc_reg) + (alpha_sh_reg[0] ? (AB + 1)'(fdiff_reg) : '0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tdl_pkg::ST_IDLE: begin
                if (s_valid) state_next = tdl_pkg::ST_DECIDE;
            end
            tdl_pkg::ST_DECIDE: begin
                if (prev_time_reg == '0 || time_in_reg == prev_time_reg) begin
                    state_next = tdl_pkg::ST_FINISH;
                end else begin
                    state_next = tdl_pkg::ST_SCALE;
                end
            end
            tdl_pkg::ST_SCALE:  state_next = tdl_pkg::ST_DIVIDE;
            tdl_pkg::ST_DIVIDE: begin
                if (div_done) state_next = tdl_pkg::ST_APPLY;
            end
            tdl_pkg::ST_APPLY: begin
                if (filter_on && primed_reg) state_next = tdl_pkg::ST_FILTER;
                else                         state_next = tdl_pkg::ST_FINISH;
            end
            tdl_pkg::ST_FILTER: begin
                if (fcnt_reg == tdl_pkg::FCNT_BITS'(AF - 1)) state_next = tdl_pkg::ST_UPDATE;
            end
            tdl_pkg::ST_UPDATE: state_next = tdl_pkg::ST_FINISH;
            tdl_pkg::ST_FINISH: begin
                if (out_free) state_next = tdl_pkg::ST_IDLE;
            end
            default: state_next = tdl_pkg::ST_IDLE;
        endcase
    end

    // state-decoded outputs
    always_comb begin
        s_ready   = (state_reg == tdl_pkg::ST_IDLE);
        div_start = (state_reg == tdl_pkg::ST_SCALE);
    end

    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_rate_value  = m_rate_reg;
    assign m_result_kind = m_kind_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= tdl_pkg::ST_IDLE;
            m_valid_reg     <= 1'b0;
            prev_sample_reg <= '0;
            prev_time_reg   <= '0;
            held_reg        <= '0;
            smooth_reg      <= '0;
            primed_reg      <= 1'b0;
            alpha_reg       <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) alpha_reg <= cfg_filter_alpha;

            if (state_reg == tdl_pkg::ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                tdl_pkg::ST_DECIDE: begin
                    if (prev_time_reg == '0) begin
                        prev_sample_reg <= sample_in_reg;
                        prev_time_reg   <= time_in_reg;
                    end
                end
                tdl_pkg::ST_DIVIDE: begin
                    if (div_done) begin
                        prev_sample_reg <= sample_in_reg;
                        prev_time_reg   <= time_in_reg;
                    end
                end
                tdl_pkg::ST_APPLY: begin
                    if (!filter_on) begin
                        held_reg <= rate_reg;
                    end else if (!primed_reg) begin
                        // first filtered value loads the smoother directly
                        smooth_reg <= rate_reg;
                        held_reg   <= rate_reg;
                        primed_reg <= 1'b1;
                    end
                end
                tdl_pkg::ST_UPDATE: begin
                    smooth_reg <= smooth_reg + RB'(acc_reg);
                    held_reg   <= smooth_reg + RB'(acc_reg);
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            tdl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    sample_in_reg <= s_sample_value;
                    time_in_reg   <= s_time_ms;
                end
            end
            tdl_pkg::ST_DECIDE: begin
                diff_reg  <= DB'(sample_in_reg) - DB'(prev_sample_reg);
                delta_reg <= time_in_reg - prev_time_reg;   // modulo 2^32
                if (prev_time_reg == '0)              kind_reg <= tdl_pkg::KIND_FIRST;
                else if (time_in_reg == prev_time_reg) kind_reg <= tdl_pkg::KIND_HOLD;
                else                                   kind_reg <= tdl_pkg::KIND_NEW;
            end
            tdl_pkg::ST_DIVIDE: begin
                if (div_done) rate_reg <= div_quotient;
            end
            tdl_pkg::ST_APPLY: begin
                fdiff_reg    <= FB'(rate_reg) - FB'(smooth_reg);
                acc_reg      <= '0;
                alpha_sh_reg <= AF'(alpha_reg);
                fcnt_reg     <= '0;
            end
            tdl_pkg::ST_FILTER: begin
                acc_reg      <= AB'(fsum >>> 1);
                alpha_sh_reg <= alpha_sh_reg >> 1;
                fcnt_reg     <= fcnt_reg + 1'b1;
            end
            tdl_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_kind_reg <= kind_reg;
                    m_rate_reg <= (kind_reg == tdl_pkg::KIND_FIRST) ? '0 : held_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/tdl_divider.sv
// Bit-serial signed divider: signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero and clamped to the rate width. Uses tdl_pkg.

module tdl_divider (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic signed [tdl_pkg::PROD_BITS-1:0]    dividend,
    input  logic        [tdl_pkg::TIME_BITS-1:0]    divisor,
    output logic                                    done,
    output logic signed [tdl_pkg::RATE_BITS-1:0]    quotient
);

    localparam int PB = tdl_pkg::PROD_BITS;
    localparam int TB = tdl_pkg::TIME_BITS;
    localparam int RB = tdl_pkg::RATE_BITS;
    localparam int WB = tdl_pkg::WIDE_BITS;
    localparam logic [WB-1:0] LIM_NEG = WB'(1) << (RB - 1);
    localparam logic [WB-1:0] LIM_POS = LIM_NEG - WB'(1);

    tdl_pkg::div_state_t state_reg, state_next;

    logic [PB-1:0]               work_reg;   // dividend bits out at top, quotient bits in at bottom
    logic [TB-1:0]               rem_reg;
    logic [TB-1:0]               divisor_reg;
    logic                        neg_reg;
    logic [tdl_pkg::DCNT_BITS-1:0] cnt_reg;

    logic [TB:0]   shifted;
    logic [TB+1:0] trial;
    logic          qbit;
    logic [WB-1:0] wide_mag;

    always_comb begin
        shifted = {rem_reg, work_reg[PB-1]};
        trial   = {1'b0, shifted} - {2'b00, divisor_reg};
        qbit    = ~trial[TB+1];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tdl_pkg::DIV_IDLE: begin
                if (start) state_next = tdl_pkg::DIV_RUN;
            end
            tdl_pkg::DIV_RUN: begin
                if (cnt_reg == tdl_pkg::DCNT_BITS'(PB - 1)) state_next = tdl_pkg::DIV_FIX;
            end
            tdl_pkg::DIV_FIX: state_next = tdl_pkg::DIV_IDLE;
            default:          state_next = tdl_pkg::DIV_IDLE;
        endcase
    end

    // sign and clamp on the finished magnitude
    always_comb begin
        done     = (state_reg == tdl_pkg::DIV_FIX);
        wide_mag = WB'(work_reg);
        if (neg_reg) begin
            if (wide_mag > LIM_NEG) quotient = {1'b1, {(RB-1){1'b0}}};
            else                    quotient = RB'(-wide_mag);
        end else begin
            if (wide_mag > LIM_POS) quotient = {1'b0, {(RB-1){1'b1}}};
            else                    quotient = RB'(wide_mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tdl_pkg::DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            tdl_pkg::DIV_IDLE: begin
                if (start) begin
                    neg_reg     <= dividend[PB-1];
                    work_reg    <= dividend[PB-1] ? PB'(-dividend) : PB'(dividend);
                    divisor_reg <= divisor;
                    rem_reg     <= '0;
                    cnt_reg     <= '0;
                end
            end
            tdl_pkg::DIV_RUN: begin
                rem_reg  <= qbit ? TB'(trial) : TB'(shifted);
                work_reg <= {work_reg[PB-2:0], qbit};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/tdl_checker.sv
// Port-level checks for the timed derivative block, bound to the top level.
// Depends on tdl_pkg.

module tdl_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [tdl_pkg::RATE_BITS-1:0]   m_rate_value,
    input logic        [tdl_pkg::KIND_BITS-1:0]   m_result_kind
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rate_value) && $stable(m_result_kind))
        else $error("result changed while stalled");

    // first-sample results always report zero rate
    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == tdl_pkg::KIND_FIRST |-> m_rate_value == '0)
        else $error("first-sample result with nonzero rate");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_kind == tdl_pkg::KIND_FIRST ||
                     m_result_kind == tdl_pkg::KIND_HOLD  ||
                     m_result_kind == tdl_pkg::KIND_NEW))
        else $error("undefined result kind");

    // one request at a time, and its result never lands the very next cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !$rose(m_valid))
        else $error("request overlap or result too early");

endmodule

bind timed_derivative_with_lowpass tdl_checker u_tdl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_rate_value  (m_rate_value),
    .m_result_kind (m_result_kind)
);

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for timed_derivative_with_lowpass: directed and random requests.
// Depends on tdl_pkg and the block's RTL; an internal predictor checks every result.

module tb;

    localparam int     CLK_HALF     = 4;
    localparam int     CYCLE_LIMIT  = 800000;
    localparam int     MAX_REPORTS  = 10;
    localparam int     STALL_CYCLES = 600;
    localparam int     DRAIN_CYCLES = 80;
    localparam longint RATE_MAX     = (64'sd1 <<< (tdl_pkg::RATE_BITS - 1)) - 1;
    localparam longint RATE_MIN     = -RATE_MAX - 1;

    // one predicted result: rate word plus its kind code
    typedef struct {
        logic signed [tdl_pkg::RATE_BITS-1:0] rate;
        tdl_pkg::kind_t                       kind;
    } rate_result_t;

    logic                                   aclk             = 1'b0;
    logic                                   aresetn          = 1'b0;
    logic                                   s_valid          = 1'b0;
    logic                                   s_ready;
    logic signed [tdl_pkg::SAMPLE_BITS-1:0] s_sample_value   = '0;
    logic        [tdl_pkg::TIME_BITS-1:0]   s_time_ms        = '0;
    logic                                   m_valid;
    logic                                   m_ready          = 1'b0;
    logic signed [tdl_pkg::RATE_BITS-1:0]   m_rate_value;
    logic        [tdl_pkg::KIND_BITS-1:0]   m_result_kind;
    logic                                   cfg_valid        = 1'b0;
    logic                                   cfg_ready;
    logic        [tdl_pkg::ALPHA_BITS-1:0]  cfg_filter_alpha = '0;

    // traffic shaping
    logic idle_on      = 1'b1;  // random gaps on both sides
    logic hold_results = 1'b0;  // receiver hold-off, timed by its own process

    // predictor copy of the block's history and weight
    longint                           prior_sample = 0;
    logic [tdl_pkg::TIME_BITS-1:0]    prior_time   = '0;
    longint                           last_rate    = 0;
    longint                           lp_state     = 0;
    logic                             lp_primed    = 1'b0;
    logic [tdl_pkg::ALPHA_BITS-1:0]   alpha_reg    = '0;

    rate_result_t rate_expected[$];

    int error_count     = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int weights_written = 0;
    int cycle_count     = 0;

    timed_derivative_with_lowpass i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_value   (s_sample_value),
        .s_time_ms        (s_time_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rate_value     (m_rate_value),
        .m_result_kind    (m_result_kind),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_filter_alpha (cfg_filter_alpha)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, rate_expected.size());
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stalls while idle_on is set, plus the long hold-off when asked.
    always @(posedge aclk) begin
        m_ready <= !hold_results && !(idle_on && $urandom_range(99) < 7);
    end

    // Long hold-off: counts its own cycles, then lets the results go.
    initial begin
        forever begin
            wait (hold_results);
            repeat (STALL_CYCLES) @(posedge aclk);
            hold_results <= 1'b0;
            @(posedge aclk);
        end
    end

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endfunction

    // Rate predictor: advances the history by one request and returns the result.
    function automatic rate_result_t predict_rate(
            input logic signed [tdl_pkg::SAMPLE_BITS-1:0] smp,
            input logic [tdl_pkg::TIME_BITS-1:0] t_ms);
        rate_result_t                  res;
        logic [tdl_pkg::TIME_BITS-1:0] gap;
        longint                        span;
        longint                        rate;
        logic signed [95:0]            nudge;
        // no history yet: a stored time of zero means nothing recorded
        if (prior_time == '0) begin
            prior_sample = smp;
            prior_time   = t_ms;
            res.rate     = '0;
            res.kind     = tdl_pkg::KIND_FIRST;
            return res;
        end
        // interval is modulo 2^32, so a backwards time is a long interval
        gap = t_ms - prior_time;
        if (gap == '0) begin
            res.rate = last_rate[tdl_pkg::RATE_BITS-1:0];
            res.kind = tdl_pkg::KIND_HOLD;
            return res;
        end
        span = gap;
        rate = ((longint'(smp) - prior_sample) * tdl_pkg::MS_PER_S) / span;
        if (rate > RATE_MAX)
            rate = RATE_MAX;
        if (rate < RATE_MIN)
            rate = RATE_MIN;
        // low-pass only for weights strictly inside (0, 1.0); first input loads it
        if (alpha_reg > 0 && alpha_reg < tdl_pkg::ALPHA_ONE) begin
            if (!lp_primed) begin
                lp_state  = rate;
                lp_primed = 1'b1;
            end else begin
                nudge    = $signed({1'b0, alpha_reg}) * (rate - lp_state);
                lp_state = lp_state + (nudge >>> tdl_pkg::ALPHA_FRAC);
            end
            last_rate = lp_state;
        end else begin
            last_rate = rate;
        end
        prior_sample = smp;
        prior_time   = t_ms;
        res.rate     = last_rate[tdl_pkg::RATE_BITS-1:0];
        res.kind     = tdl_pkg::KIND_NEW;
        return res;
    endfunction

    // Scoreboard: results are compared before new requests are queued, so a
    // stray result can never match a request taken on the same edge.
    always @(posedge aclk) begin : scoreboard
        rate_result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                alpha_reg = cfg_filter_alpha;
            if (m_valid && m_ready) begin
                results_checked++;
                if (rate_expected.size() == 0) begin
                    flag_error($sformatf("result with nothing pending: rate %h kind %0d",
                                         m_rate_value, m_result_kind));
                end else begin
                    want = rate_expected.pop_front();
                    if (m_rate_value !== want.rate || m_result_kind !== want.kind)
                        flag_error($sformatf("rate exp %h got %h, kind exp %0d got %0d",
                                             want.rate, m_rate_value, want.kind,
                                             m_result_kind));
                end
            end
            if (s_valid && s_ready)
                rate_expected.push_back(predict_rate(s_sample_value, s_time_ms));
        end
    end

    // Offer one request and return on the edge that takes it. Valid is left high
    // so the next call can reuse it; callers lower it before waiting on anything.
    task automatic send_sample(input logic signed [tdl_pkg::SAMPLE_BITS-1:0] smp,
                               input logic [tdl_pkg::TIME_BITS-1:0] t_ms);
        int pause;
        if (idle_on && $urandom_range(99) < 7) begin
            pause = $urandom_range(1, 80);
            s_valid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_sample_value <= smp;
        s_time_ms      <= t_ms;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
    endtask

    // Wait until every pending result is back, then write the weight.
    task automatic write_alpha(input logic [tdl_pkg::ALPHA_BITS-1:0] weight);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rate_expected.size() != 0) @(posedge aclk);
        cfg_valid        <= 1'b1;
        cfg_filter_alpha <= weight;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        weights_written++;
    endtask

    // No history, a zero time that keeps it empty, a hold before any rate,
    // and a time that wraps past 2^32.
    task automatic test_first_sample();
        send_sample(32'sh7FFFFFFF, 32'd0);
        send_sample(32'sh80000000, 32'd0);
        send_sample(32'sh00010000, 32'hFFFFFFFF);
        send_sample(32'sh12345678, 32'hFFFFFFFF);
        send_sample(32'sh00020000, 32'd5);
        send_sample(32'sh0BADCAFE, 32'd5);
    endtask

    // Largest steps over one millisecond, a backwards time, and a stored zero
    // time that drops the block back to no history.
    task automatic test_extremes();
        send_sample(32'sh80000000, 32'd6);
        send_sample(32'sh7FFFFFFF, 32'd7);
        send_sample(32'sh80000000, 32'd8);
        send_sample(32'sh00000000, 32'd3);
        send_sample(32'sh00000000, 32'd0);
        send_sample(32'sh00000005, 32'd100);
    endtask

    // Weight edges: smallest, half and largest active, 1.0, the register maximum, off.
    task automatic test_filter_weights();
        logic [tdl_pkg::ALPHA_BITS-1:0] weights[6];
        logic [tdl_pkg::TIME_BITS-1:0]  t_ms;
        weights = '{17'd1, 17'd32768, 17'd65535, 17'd65536, 17'd131071, 17'd0};
        t_ms = 32'd200;
        foreach (weights[k]) begin
            write_alpha(weights[k]);
            t_ms += 32'd17;
            send_sample($signed($urandom), t_ms);
            send_sample($signed($urandom), t_ms);
        end
    endtask

    // Receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        logic [tdl_pkg::TIME_BITS-1:0] t_ms;
        write_alpha(17'd20000);
        t_ms = 32'd1000;
        hold_results <= 1'b1;
        for (int i = 0; i < 16; i++) begin
            t_ms += $urandom_range(1, 50);
            send_sample($signed($urandom) >>> 8, t_ms);
        end
    endtask

    // Random traffic in phases, each under its own weight. Mostly a walking
    // signal with rising times; the rest are holds, jumps, noise and zero times.
    task automatic run_random_stream(input int count,
                                     input logic [tdl_pkg::ALPHA_BITS-1:0] weight);
        logic signed [tdl_pkg::SAMPLE_BITS-1:0] level;
        logic signed [tdl_pkg::SAMPLE_BITS-1:0] smp;
        logic [tdl_pkg::TIME_BITS-1:0]          clock_ms;
        logic [tdl_pkg::TIME_BITS-1:0]          t_ms;
        int                                     pick;
        write_alpha(weight);
        level    = $signed($urandom);
        clock_ms = $urandom_range(1, 5000);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                level    = level + ($signed($urandom) >>> $urandom_range(8, 31));
                clock_ms = clock_ms + $urandom_range(1, 1000);
                smp      = level;
            end else if (pick < 88) begin
                smp = $signed($urandom);           // same time: held result
            end else if (pick < 92) begin
                clock_ms = clock_ms + $urandom;    // may wrap backwards
                smp      = $signed($urandom);
            end else if (pick < 96) begin
                clock_ms = $urandom;
                smp      = $signed($urandom);
            end else begin
                clock_ms = '0;                     // forget the history
                smp      = $signed($urandom);
            end
            t_ms = clock_ms;
            send_sample(smp, t_ms);
        end
    endtask

    task automatic test_random_traffic();
        run_random_stream(240, tdl_pkg::ALPHA_BITS'($urandom_range(1, 65535)));
        run_random_stream(240, 17'd0);
        idle_on = 1'b0;                            // long run with no gaps at all
        run_random_stream(240, tdl_pkg::ALPHA_BITS'($urandom_range(1, 255)));
        idle_on = 1'b1;
        run_random_stream(240, tdl_pkg::ALPHA_BITS'(32'd65536 + $urandom_range(0, 65535)));
        run_random_stream(240, tdl_pkg::ALPHA_BITS'($urandom_range(65000, 65535)));
        run_random_stream(240, tdl_pkg::ALPHA_BITS'($urandom_range(1, 65535)));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_sample();
        test_extremes();
        test_filter_weights();
        test_backpressure();
        test_random_traffic();

        // let everything drain, then give stray results time to show up
        s_valid <= 1'b0;
        @(posedge aclk);
        while (rate_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests sent, %0d results checked across %0d weight writes",
                 requests_sent, results_checked, weights_written);
        $display("%0d mismatches in %0d cycles", error_count, cycle_count);
        if (error_count == 0 && rate_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
